FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the checker in pwc_checker.sv
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is applied
`define PWC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define PWC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/pwc_pkg.sv
// ---------------------------------------------------------------------------
// pwc_pkg
// Types and constants of the palindrome word counter.
// ---------------------------------------------------------------------------
package pwc_pkg;

    localparam int LETTER_W = 5;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 2;

    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FORMAT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // block sequencer
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // message parser
    typedef enum logic [3:0] {
        PS_START  = 4'b0001,
        PS_ERROR  = 4'b0010,
        PS_SPACE  = 4'b0100,
        PS_LETTER = 4'b1000
    } ps_t;

    // walker status towards the sequencer
    typedef struct packed {
        logic done;
        logic is_pal;
    } walk_stat_t;

endpackage

FILE: sv/palindrome_word_counter.sv
// ---------------------------------------------------------------------------
// palindrome_word_counter
// Counts words and palindromic words of a byte stream message.
// ---------------------------------------------------------------------------
// Input: one message byte per word on s_tdata, s_tlast on the final byte.
// Body must be letters in words split by single spaces; a final LF or CR LF
// is stripped and reported on m_tuser.
// Output: one word per message, sent after the last byte: palindrome and
// word counts on m_tdata, status and newline flag on m_tuser.
// Input flow: bytes are taken back to back, except one that closes a word
// (a space, or the last byte ending in a letter): the walker then compares
// the letter store from both ends, one pair per cycle over the two read
// ports, before the next byte is taken.
// s_tready is low during that walk and while a result is being loaded.
// Result: after the last byte, and after the walk if the message ends in a
// letter, the result is loaded into the output register and m_tvalid rises.
// Stall: the result sits in an output register; bytes of the next message
// are still taken up to its last one, whose result then waits with s_tready
// low until m_tready frees the register.
// Reset: parser, counters and handshakes clear at once; the letter store
// needs no clearing, as only letters of the current word are read.
// ---------------------------------------------------------------------------
module palindrome_word_counter #(
    parameter int MAX_WORD_LEN = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // is_last
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] palindrome_count, [31:16] word_count
    output logic [2:0]  m_tuser    // [1:0] status, [2] line_end
);
    import pwc_pkg::*;

    localparam int ADDR_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);

    state_t               state_reg, state_next;
    ps_t                  ps_reg, ps_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [COUNT_W-1:0]   pal_cnt_reg, pal_cnt_next;
    logic [COUNT_W-1:0]   word_cnt_reg, word_cnt_next;
    logic                 cr_reg, cr_next;        // CR held back
    logic                 ovf_reg, ovf_next;      // a word outgrew the store
    logic                 nl_reg, nl_next;        // line end stripped
    logic                 fin_reg, fin_next;      // emit after the walk
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [31:0]          m_tdata_reg, m_tdata_next;
    logic [2:0]           m_tuser_reg, m_tuser_next;

    logic                 is_letter;
    logic                 go_finish;
    logic                 close_req;
    logic                 load_out;
    logic                 we;
    logic                 walk_start;
    logic [ADDR_W-1:0]    raddr_a, raddr_b;
    logic [LETTER_W-1:0]  rdata_a, rdata_b;
    walk_stat_t           wstat;

    assign is_letter = ((s_tdata >= CH_UPPER_A) && (s_tdata <= CH_UPPER_Z)) ||
                       ((s_tdata >= CH_LOWER_A) && (s_tdata <= CH_LOWER_Z));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb
    begin
        state_next    = state_reg;
        ps_next       = ps_reg;
        len_next      = len_reg;
        pal_cnt_next  = pal_cnt_reg;
        word_cnt_next = word_cnt_reg;
        cr_next       = cr_reg;
        ovf_next      = ovf_reg;
        nl_next       = nl_reg;
        fin_next      = fin_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        go_finish     = 1'b0;
        close_req     = 1'b0;
        load_out      = 1'b0;
        we            = 1'b0;
        walk_start    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (cr_reg)
                    begin
                        cr_next = 1'b0;
                        if (s_tlast && (s_tdata == CH_LF))
                        begin
                            nl_next   = 1'b1;
                            go_finish = 1'b1;
                        end
                        else
                        begin
                            ps_next   = PS_ERROR;
                            go_finish = s_tlast;
                        end
                    end
                    else if (s_tlast && (s_tdata == CH_LF))
                    begin
                        nl_next   = 1'b1;
                        go_finish = 1'b1;
                    end
                    else if (!s_tlast && (s_tdata == CH_CR))
                    begin
                        cr_next = 1'b1;
                    end
                    else
                    begin
                        go_finish = s_tlast;
                        case (ps_reg)
                            PS_START, PS_SPACE:
                            begin
                                ps_next = is_letter ? PS_LETTER : PS_ERROR;
                            end
                            PS_LETTER:
                            begin
                                if (!is_letter)
                                begin
                                    if (s_tdata == CH_SPACE)
                                    begin
                                        close_req = 1'b1;
                                        ps_next   = PS_SPACE;
                                    end
                                    else
                                    begin
                                        ps_next = PS_ERROR;
                                    end
                                end
                            end
                            default:
                            begin
                                ps_next = ps_reg;
                            end
                        endcase
                        // letters past the store are dropped and flagged
                        if (is_letter && (ps_reg != PS_ERROR))
                        begin
                            if (len_reg < LEN_W'(MAX_WORD_LEN))
                            begin
                                we       = 1'b1;
                                len_next = len_reg + LEN_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                    end

                    if (go_finish)
                    begin
                        fin_next = 1'b1;
                        if (ps_next == PS_LETTER)
                        begin
                            walk_start = 1'b1;
                            state_next = ST_WALK;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                    else if (close_req)
                    begin
                        fin_next   = 1'b0;
                        walk_start = 1'b1;
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                if (wstat.done)
                begin
                    if (word_cnt_reg != COUNT_MAX)
                    begin
                        word_cnt_next = word_cnt_reg + COUNT_W'(1);
                    end
                    if (wstat.is_pal && (pal_cnt_reg != COUNT_MAX))
                    begin
                        pal_cnt_next = pal_cnt_reg + COUNT_W'(1);
                    end
                    len_next   = '0;
                    state_next = fin_reg ? ST_EMIT : ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out = 1'b1;
                    case (ps_reg)
                        PS_ERROR, PS_SPACE:
                        begin
                            m_tdata_next = '0;
                            m_tuser_next = {nl_reg, STATUS_FORMAT};
                        end
                        PS_LETTER:
                        begin
                            if (ovf_reg)
                            begin
                                m_tdata_next = '0;
                                m_tuser_next = {nl_reg, STATUS_OVERFLOW};
                            end
                            else
                            begin
                                m_tdata_next = {word_cnt_reg, pal_cnt_reg};
                                m_tuser_next = {nl_reg, STATUS_OK};
                            end
                        end
                        default:
                        begin
                            m_tdata_next = '0;
                            m_tuser_next = {nl_reg, STATUS_OK};
                        end
                    endcase
                    // back to the reset state for the next message
                    ps_next       = PS_START;
                    len_next      = '0;
                    pal_cnt_next  = '0;
                    word_cnt_next = '0;
                    cr_next       = 1'b0;
                    ovf_next      = 1'b0;
                    nl_next       = 1'b0;
                    fin_next      = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ps_reg       <= PS_START;
            len_reg      <= '0;
            pal_cnt_reg  <= '0;
            word_cnt_reg <= '0;
            cr_reg       <= 1'b0;
            ovf_reg      <= 1'b0;
            nl_reg       <= 1'b0;
            fin_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ps_reg       <= ps_next;
            len_reg      <= len_next;
            pal_cnt_reg  <= pal_cnt_next;
            word_cnt_reg <= word_cnt_next;
            cr_reg       <= cr_next;
            ovf_reg      <= ovf_next;
            nl_reg       <= nl_next;
            fin_reg      <= fin_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // letters folded to 5 bits so case is ignored
    pwc_word_mem #(
        .DEPTH  (MAX_WORD_LEN),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .we      (we),
        .waddr   (len_reg[ADDR_W-1:0]),
        .wdata   (s_tdata[LETTER_W-1:0]),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // walk starts the cycle after the closing byte's write, so no forwarding
    pwc_walker #(
        .ADDR_W (ADDR_W),
        .LEN_W  (LEN_W)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (walk_start),
        .len     (len_next),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .stat    (wstat)
    );

endmodule

FILE: sv/pwc_word_mem.sv
// ---------------------------------------------------------------------------
// pwc_word_mem
// Letter store: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module pwc_word_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [ADDR_W-1:0]            waddr,
    input  logic [pwc_pkg::LETTER_W-1:0] wdata,
    input  logic [ADDR_W-1:0]            raddr_a,
    input  logic [ADDR_W-1:0]            raddr_b,
    output logic [pwc_pkg::LETTER_W-1:0] rdata_a,
    output logic [pwc_pkg::LETTER_W-1:0] rdata_b
);
    import pwc_pkg::*;

    logic [LETTER_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: sv/pwc_walker.sv
// ---------------------------------------------------------------------------
// pwc_walker
// Compares a stored word from both ends, one pair of letters a cycle.
// ---------------------------------------------------------------------------
module pwc_walker #(
    parameter int ADDR_W = 6,
    parameter int LEN_W  = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [LEN_W-1:0]             len,
    output logic [ADDR_W-1:0]            raddr_a,
    output logic [ADDR_W-1:0]            raddr_b,
    input  logic [pwc_pkg::LETTER_W-1:0] rdata_a,
    input  logic [pwc_pkg::LETTER_W-1:0] rdata_b,
    output pwc_pkg::walk_stat_t          stat
);
    import pwc_pkg::*;

    logic             busy_reg;
    logic             rdv_reg;
    logic             pal_reg;
    logic [LEN_W-1:0] idx_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] half;
    logic [LEN_W-1:0] tail;
    logic             issue;
    logic             done;

    assign half  = len_reg >> 1;
    assign tail  = len_reg - LEN_W'(1) - idx_reg;
    assign issue = busy_reg && (idx_reg < half);
    // finished once every pair is issued and the last compare has landed
    assign done  = busy_reg && !issue && !rdv_reg;

    assign raddr_a = idx_reg[ADDR_W-1:0];
    assign raddr_b = tail[ADDR_W-1:0];

    assign stat.done   = done;
    assign stat.is_pal = pal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rdv_reg  <= 1'b0;
            pal_reg  <= 1'b1;
            idx_reg  <= '0;
            len_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            rdv_reg  <= 1'b0;
            pal_reg  <= 1'b1;
            idx_reg  <= '0;
            len_reg  <= len;
        end
        else
        begin
            rdv_reg <= issue;
            if (issue)
            begin
                idx_reg <= idx_reg + LEN_W'(1);
            end
            if (rdv_reg && (rdata_a != rdata_b))
            begin
                pal_reg <= 1'b0;
            end
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: sv/pwc_checker.sv
// ---------------------------------------------------------------------------
// pwc_checker
// Port-level checks on the result channel of the word counter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pwc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import pwc_pkg::*;

    // stalled result holds
    `PWC_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tuser}), "stall change")

    // no status code beyond overflow
    `PWC_ASSERT(a_status, m_tvalid |-> m_tuser[1:0] <= STATUS_OVERFLOW, "undefined status code")

    // failed messages carry zero counts
    `PWC_ASSERT(a_err_zero, m_tvalid && (m_tuser[1:0] != STATUS_OK) |-> m_tdata == 32'd0, "counts on error")

    // palindromes are a subset of the words
    `PWC_ASSERT(a_subset, m_tvalid |-> m_tdata[15:0] <= m_tdata[31:16], "more palindromes than words")

    // nothing offered while in reset
    `PWC_ASSERT_RST(a_reset, !rst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind palindrome_word_counter pwc_checker u_pwc_checker (.*);

FILE: sim/palindrome_word_counter_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// palindrome_word_counter_tb
// Self-checking bench for the palindrome word counter. Messages go in one
// byte per input word. A byte-level parser in the bench predicts the word
// counts, status and newline flag of each message. Every result word is
// compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module palindrome_word_counter_tb;

    import pwc_pkg::*;

    localparam int WORD_STORE_DEPTH = 64;
    localparam int WATCHDOG_LIMIT   = 3000;  // cycles with no handshake on either side
    localparam int END_SETTLE       = 60;    // longest walk plus load, with margin
    localparam int HOLDOFF_CYCLES   = 300;
    localparam int RANDOM_BYTES     = 120;
    localparam int RANDOM_MESSAGES  = 6;

    // One expected result word
    typedef struct packed {
        logic [COUNT_W-1:0]  pal;
        logic [COUNT_W-1:0]  words;
        logic [STATUS_W-1:0] status;
        logic                newline;
    } count_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b1;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    // Predictor state: a copy of the parser, the letter store and the counters
    ps_t                parse_st = PS_START;
    logic [4:0]         letters [WORD_STORE_DEPTH];
    int                 word_len;
    logic [COUNT_W-1:0] pal_seen;
    logic [COUNT_W-1:0] words_seen;
    bit                 cr_held;
    bit                 overflow;

    count_result_t expected_counts[$];
    logic [7:0]    msg_buf[$];

    int mismatch_count;
    int bytes_accepted;
    int idle_cycles;

    // Idling controls; the hold-off request is handed to the receiver process
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    int rx_hold_req;
    int rx_hold_left;
    int rx_stall_left;

    palindrome_word_counter #(
        .MAX_WORD_LEN(WORD_STORE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] data_byte
        .s_tlast  (s_tlast),   // is_last
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [15:0] palindrome_count, [31:16] word_count
        .m_tuser  (m_tuser)    // [1:0] status, [2] line_end
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    function automatic bit is_letter(logic [7:0] b);
        return (b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z);
    endfunction

    function automatic void clear_parser();
        parse_st   = PS_START;
        word_len   = 0;
        pal_seen   = '0;
        words_seen = '0;
        cr_held    = 1'b0;
        overflow   = 1'b0;
    endfunction

    // Letters past the store depth are dropped but poison the message
    function automatic void store_letter(logic [7:0] b);
        if (word_len < WORD_STORE_DEPTH)
        begin
            letters[word_len] = b[4:0];
            word_len++;
        end
        else
            overflow = 1'b1;
    endfunction

    function automatic void close_word();
        bit mirror;
        mirror = 1'b1;
        for (int i = 0; i < word_len / 2; i++)
            if (letters[i] != letters[word_len - 1 - i])
                mirror = 1'b0;
        if (words_seen != COUNT_MAX)
            words_seen++;
        if (mirror && pal_seen != COUNT_MAX)
            pal_seen++;
        word_len = 0;
    endfunction

    function automatic void take_byte(logic [7:0] b);
        case (parse_st)
            PS_START, PS_SPACE:
                if (is_letter(b))
                begin
                    store_letter(b);
                    parse_st = PS_LETTER;
                end
                else
                    parse_st = PS_ERROR;
            PS_LETTER:
                if (is_letter(b))
                    store_letter(b);
                else if (b == CH_SPACE)
                begin
                    close_word();
                    parse_st = PS_SPACE;
                end
                else
                    parse_st = PS_ERROR;
            default: ;
        endcase
    endfunction

    // A format error outranks an overflow; counts read zero unless status is OK
    function automatic void finish_message(bit nl);
        count_result_t r;
        r = '0;
        if (parse_st == PS_ERROR || parse_st == PS_SPACE)
            r.status = STATUS_FORMAT;
        else if (parse_st == PS_LETTER)
        begin
            close_word();
            if (overflow)
                r.status = STATUS_OVERFLOW;
            else
            begin
                r.pal   = pal_seen;
                r.words = words_seen;
                r.status = STATUS_OK;
            end
        end
        r.newline = nl;
        expected_counts.push_back(r);
        clear_parser();
    endfunction

    // A CR is held back until the next byte shows whether it opens a final CR LF
    function automatic void predict_byte(logic [7:0] b, bit last);
        if (cr_held)
        begin
            cr_held = 1'b0;
            if (last && b == CH_LF)
                finish_message(1'b1);
            else
            begin
                parse_st = PS_ERROR;
                if (last)
                    finish_message(1'b0);
            end
        end
        else if (last && b == CH_LF)
            finish_message(1'b1);
        else if (!last && b == CH_CR)
            cr_held = 1'b1;
        else
        begin
            take_byte(b);
            if (last)
                finish_message(1'b0);
        end
    endfunction

    // -----------------------------------------------------------------------
    // Checking
    // -----------------------------------------------------------------------

    function automatic void report_error(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endfunction

    function automatic void check_result();
        count_result_t want;
        if (expected_counts.size() == 0)
        begin
            report_error($sformatf("result with none pending: tdata %h tuser %h",
                                   m_tdata, m_tuser));
            return;
        end
        want = expected_counts.pop_front();
        if (m_tdata[15:0] !== want.pal)
            report_error($sformatf("palindrome_count %0d, expected %0d",
                                   m_tdata[15:0], want.pal));
        if (m_tdata[31:16] !== want.words)
            report_error($sformatf("word_count %0d, expected %0d",
                                   m_tdata[31:16], want.words));
        if (m_tuser[1:0] !== want.status)
            report_error($sformatf("status %0d, expected %0d", m_tuser[1:0], want.status));
        if (m_tuser[2] !== want.newline)
            report_error($sformatf("line_end %0b, expected %0b", m_tuser[2], want.newline));
    endfunction

    // Mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Receiver: checks on each handshake, then decides m_tready for the next cycle.
    // A hold-off request overrides the ordinary random stalls.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (rx_hold_req > 0)
            begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end
            else if (rx_stall_left > 0)
            begin
                m_tready <= 1'b0;
                rx_stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (rx_gaps && $urandom_range(0, 2) == 0)
                    rx_stall_left = pick_gap();
            end
        end
    end

    // Watchdog: too long without a handshake on either side ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // Valid is only dropped when a gap is taken, so it never falls and rises in one step
    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_byte(b, last);
        bytes_accepted++;
    endtask

    task automatic send_message();
        int n;
        n = msg_buf.size();
        for (int i = 0; i < n; i++)
            send_byte(msg_buf[i], i == n - 1);
        msg_buf.delete();
    endtask

    // Sender pause: nothing offered until every pending result is back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_counts.size() != 0);
    endtask

    function automatic void add_byte(logic [7:0] b);
        msg_buf.push_back(b);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            msg_buf.push_back(s[i]);
    endfunction

    // Random letters with random case; a mirrored word differs only in case
    function automatic void add_word(int len, bit mirror);
        int         base [0:127];
        logic [7:0] ch;
        for (int i = 0; i < len; i++)
        begin
            if (mirror && (len - 1 - i) < i)
                base[i] = base[len - 1 - i];
            else
                base[i] = $urandom_range(0, 25);
            ch = ($urandom_range(0, 1) != 0) ? CH_UPPER_A : CH_LOWER_A;
            msg_buf.push_back(ch + base[i][7:0]);
        end
    endfunction

    // Mostly well-formed text, about a quarter of it damaged in some way
    function automatic void build_random_message();
        int         nwords;
        int         len;
        int         r;
        int         pos;
        logic [7:0] stray;
        nwords = $urandom_range(1, 4);
        for (int w = 0; w < nwords; w++)
        begin
            if (w > 0)
                add_byte(CH_SPACE);
            r = $urandom_range(0, 99);
            if (r < 85)
                len = $urandom_range(1, 6);
            else if (r < 97)
                len = $urandom_range(7, 20);
            else
                len = $urandom_range(60, 70);
            add_word(len, $urandom_range(0, 2) == 0);
        end
        r = $urandom_range(0, 4);
        if (r == 3)
            add_byte(CH_LF);
        else if (r == 4)
        begin
            add_byte(CH_CR);
            add_byte(CH_LF);
        end
        if ($urandom_range(0, 3) != 0)
            return;
        pos = $urandom_range(0, msg_buf.size() - 1);
        case ($urandom_range(0, 5))
            0: msg_buf[pos] = 8'($urandom_range(0, 255));
            1: msg_buf.insert(pos, CH_SPACE);
            2: msg_buf.insert(pos, CH_CR);
            3: msg_buf.insert(pos, CH_LF);
            4:
            begin
                msg_buf.delete();
                repeat ($urandom_range(1, 4))
                    msg_buf.push_back(8'($urandom_range(0, 255)));
            end
            default:
            begin
                r = $urandom_range(0, 2);
                stray = (r == 0) ? CH_SPACE : ((r == 1) ? CH_CR : CH_LF);
                msg_buf.push_back(stray);
            end
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Short messages for each parser rule and the byte extremes
    task automatic test_directed_cases();
        add_byte(CH_LF);                              // bare line end gives 0/0
        send_message();
        add_byte(CH_CR);
        add_byte(CH_LF);
        send_message();
        add_text("AzZa");                             // letter bounds, case folding
        send_message();
        add_text("Ab c");
        add_byte(CH_LF);
        send_message();
        add_text(" a");                               // leading space
        send_message();
        add_text("a");                                // CR not followed by LF
        add_byte(CH_CR);
        add_text("b");
        send_message();
        add_text("a");                                // CR as the last byte
        add_byte(CH_CR);
        send_message();
        add_byte(CH_LF);                              // LF before the end
        add_text("a");
        send_message();
        add_byte(8'h00);
        send_message();
        add_byte(8'hFF);
        send_message();
        add_text("a ");                               // trailing space
        send_message();
    endtask

    // Words at and past the store depth, and an overflow beaten by a format error
    task automatic test_long_words();
        add_word(WORD_STORE_DEPTH, 1'b1);
        send_message();
        add_word(WORD_STORE_DEPTH + 1, 1'b0);
        send_message();
        add_text("ab ");
        add_word(WORD_STORE_DEPTH + 2, 1'b1);
        add_text(" x");
        add_byte(CH_LF);
        send_message();
        add_word(WORD_STORE_DEPTH + 6, 1'b0);
        add_byte(CH_SPACE);
        send_message();
    endtask

    // Neither side idles for a stretch
    task automatic test_back_to_back();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        repeat (4)
        begin
            build_random_message();
            send_message();
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // Receiver holds off while bytes keep coming, so the block backs up
    task automatic test_output_holdoff();
        tx_gaps     = 1'b0;
        rx_hold_req = HOLDOFF_CYCLES;
        repeat (8)
        begin
            add_word($urandom_range(1, 3), 1'b1);
            send_message();
        end
        tx_gaps = 1'b1;
        wait_for_results();
    endtask

    task automatic test_random_messages();
        int start_bytes;
        int messages;
        start_bytes = bytes_accepted;
        messages    = 0;
        while (bytes_accepted - start_bytes < RANDOM_BYTES || messages < RANDOM_MESSAGES)
        begin
            build_random_message();
            send_message();
            messages++;
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        clear_parser();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_long_words();
        test_back_to_back();
        test_output_holdoff();
        test_random_messages();

        wait_for_results();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
